FILE: rtl/psn_ring_retransmit_buffer_top_macros.svh
// Assertion macros for the retransmit buffer checker.
// Used by prrb_chk only; needs nothing else.
`ifndef PSN_RING_RETRANSMIT_BUFFER_TOP_MACROS_SVH
`define PSN_RING_RETRANSMIT_BUFFER_TOP_MACROS_SVH

// pre holds at an edge -> post holds at the next edge
`define PRRB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

// pre holds at an edge -> post holds at the same edge
`define PRRB_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

FILE: rtl/prrb_pkg.sv
// Shared types and constants of the psn ring retransmit buffer.
// No dependencies; used by the top level and the checker.
package prrb_pkg;

	// ring depth must be a power of two: slot index is the low bits of psn - base
	localparam int RING_DEPTH = 4096;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int PSN_W      = 32;
	localparam int LEN_W      = 16;
	localparam int QP_W       = 24;
	localparam int TAG_W      = 32;
	localparam int HELD_W     = 13;
	localparam int BYTES_W    = 32;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [BYTES_W-1:0] LIMIT_RESET = 32'd104857600;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PSN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_LEN  = 2'd1,
		STAT_OVER_LIM = 2'd2,
		STAT_MISS     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	// request payload, psn in the low bits
	typedef struct packed {
		logic [TAG_W-1:0] buffer_tag;
		logic [QP_W-1:0]  queue_pair;
		logic [LEN_W-1:0] length;
		logic [PSN_W-1:0] psn;
	} req_t;

	localparam int IN_DATA_W = $bits(req_t);

	// response payload, found_length in the low bits
	typedef struct packed {
		logic [PSN_W-1:0]   acked_psn;
		logic [PSN_W-1:0]   highest_psn;
		logic [PSN_W-1:0]   lowest_psn;
		logic [BYTES_W-1:0] held_bytes;
		logic [HELD_W-1:0]  held_count;
		logic [TAG_W-1:0]   found_tag;
		logic [QP_W-1:0]    found_qp;
		logic [LEN_W-1:0]   found_length;
	} resp_t;

	localparam int OUT_FIELDS_W = $bits(resp_t);
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int FOUND_W      = LEN_W + QP_W + TAG_W;

	typedef struct packed {
		logic             valid;
		logic [PSN_W-1:0] psn;
		logic [LEN_W-1:0] length;
		logic [QP_W-1:0]  qp;
		logic [TAG_W-1:0] tag;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: rtl/prrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module prrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/psn_ring_retransmit_buffer_top.sv
// Retransmit slot ring for one connection: insert, acknowledge and lookup by psn.
// Depends on prrb_pkg and prrb_ram (slot memory).
//
//  channel   direction  signals                                   payload
//  s_*       in         s_tvalid s_tready s_tuser s_tdata         request
//  m_*       out        m_tvalid m_tready m_tuser m_tdata         result
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data    register write
//
// Insert, lookup and a stale acknowledge go through S_EXEC to a registered result.
// An acknowledge walks the slot memory one slot a cycle over the psn window it
// releases, at most the whole ring, and then gives its result.
// After reset and after every base psn write a clearing pass writes each slot
// once; no request is taken meanwhile.
// A result waiting on m_tready holds off the next request, as does a pending
// register write; register writes are always taken.
module psn_ring_retransmit_buffer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [prrb_pkg::CMD_W-1:0]          s_tuser,   // command
	input  logic [prrb_pkg::IN_DATA_W-1:0]      s_tdata,   // psn, length, queue_pair, buffer_tag
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [prrb_pkg::STAT_W-1:0]         m_tuser,   // status
	// found_length, found_qp, found_tag, held_count, held_bytes, lowest_psn,
	// highest_psn, acked_psn, zero pad
	output logic [prrb_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prrb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prrb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import prrb_pkg::*;

	state_t state_q, state_d;

	logic [PSN_W-1:0]   base_psn_q;
	logic [BYTES_W-1:0] byte_limit_q;
	logic [PSN_W-1:0]   ack_q, ack_d;
	logic [PSN_W-1:0]   low_q, low_d;
	logic [PSN_W-1:0]   high_q, high_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [BYTES_W-1:0] bytes_q, bytes_d;

	cmd_t               cmd_q;
	req_t               req_q;
	req_t               req_in;
	logic [IDX_W-1:0]   idx_q;

	logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;
	logic [IDX_W-1:0]   scan_addr_q, scan_addr_d;
	logic [CNT_W-1:0]   scan_left_q, scan_left_d;
	logic               scan_pend_s1;
	logic [IDX_W-1:0]   scan_addr_s1;
	logic               scan_rd;

	logic               m_tvalid_q;
	logic [STAT_W-1:0]  m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic               acc;
	logic               cfg_first_wr;
	logic [PSN_W-1:0]   in_delta;
	logic [IDX_W-1:0]   in_idx;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	slot_t              wr_slot;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [SLOT_W-1:0]  rd_data;
	slot_t              rd_slot;

	// insert and acknowledge arithmetic
	logic [BYTES_W-1:0] bytes_drop;
	logic [CNT_W-1:0]   cnt_drop;
	logic [BYTES_W:0]   bytes_sum;
	logic               over_lim;
	logic               in_order;
	logic [PSN_W-1:0]   span;
	logic [PSN_W-1:0]   start_delta;
	logic               scan_hit;

	logic               resp_load;
	status_t            resp_status;
	resp_t              resp;

	assign cfg_ready    = 1'b1;
	assign cfg_first_wr = cfg_valid && (cfg_index == CFG_BASE_PSN);
	assign s_tready     = (state_q == S_IDLE) && (!m_tvalid_q || m_tready) && !cfg_valid;
	assign acc          = s_tvalid && s_tready;
	assign req_in       = req_t'(s_tdata);
	assign in_delta     = req_in.psn - base_psn_q;
	assign in_idx       = in_delta[IDX_W-1:0];

	assign scan_rd      = (state_q == S_SCAN) && (scan_left_q != '0);
	assign rd_en        = acc || scan_rd;
	assign rd_addr      = scan_rd ? scan_addr_q : in_idx;
	assign rd_slot      = slot_t'(rd_data);

	prrb_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (RING_DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign bytes_drop  = bytes_q - (rd_slot.valid ? {{(BYTES_W-LEN_W){1'b0}}, rd_slot.length}
		: '0);
	assign cnt_drop    = cnt_q - CNT_W'(rd_slot.valid);
	assign bytes_sum   = {1'b0, bytes_drop} + {{(BYTES_W+1-LEN_W){1'b0}}, req_q.length};
	assign over_lim    = bytes_sum > {1'b0, byte_limit_q};
	assign in_order    = (req_q.psn == ack_q + PSN_W'(1)) && (ack_q != '1);
	assign span        = req_q.psn - ack_q;
	assign start_delta = ack_q + PSN_W'(1) - base_psn_q;
	assign scan_hit    = scan_pend_s1 && rd_slot.valid && (rd_slot.psn > ack_q)
		&& (rd_slot.psn <= req_q.psn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ack_d       = ack_q;
		low_d       = low_q;
		high_d      = high_q;
		cnt_d       = cnt_q;
		bytes_d     = bytes_q;
		clr_idx_d   = clr_idx_q;
		scan_addr_d = scan_addr_q;
		scan_left_d = scan_left_q;
		wr_en       = 1'b0;
		wr_addr     = idx_q;
		wr_slot     = '0;
		resp_load   = 1'b0;
		resp_status = STAT_OK;
		resp        = '0;

		case (state_q)
			S_CLEAR: begin
				wr_en     = 1'b1;
				wr_addr   = clr_idx_q;
				clr_idx_d = clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(RING_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (cmd_q)
					CMD_INSERT: begin
						resp_load = 1'b1;
						if (req_q.length == '0) begin
							resp_status = STAT_BAD_LEN;
						end else begin
							// old occupant is released first in every case
							wr_en   = 1'b1;
							bytes_d = bytes_drop;
							cnt_d   = cnt_drop;
							if (over_lim) begin
								resp_status = STAT_OVER_LIM;
							end else begin
								low_d  = (req_q.psn < low_q) ? req_q.psn : low_q;
								high_d = (req_q.psn > high_q) ? req_q.psn : high_q;
								if (in_order) begin
									// stored and acknowledged at once: slot ends empty
									ack_d = req_q.psn;
								end else begin
									wr_slot.valid  = 1'b1;
									wr_slot.psn    = req_q.psn;
									wr_slot.length = req_q.length;
									wr_slot.qp     = req_q.queue_pair;
									wr_slot.tag    = req_q.buffer_tag;
									bytes_d        = bytes_sum[BYTES_W-1:0];
									cnt_d          = cnt_drop + CNT_W'(1);
								end
							end
						end
					end
					CMD_ACK: begin
						if (req_q.psn <= ack_q) begin
							resp_load = 1'b1;
						end else begin
							state_d = S_SCAN;
							if (span >= PSN_W'(RING_DEPTH)) begin
								scan_addr_d = '0;
								scan_left_d = CNT_W'(RING_DEPTH);
							end else begin
								scan_addr_d = start_delta[IDX_W-1:0];
								scan_left_d = span[CNT_W-1:0];
							end
						end
					end
					CMD_LOOKUP: begin
						resp_load = 1'b1;
						if (rd_slot.valid && (rd_slot.psn == req_q.psn)) begin
							resp.found_length = rd_slot.length;
							resp.found_qp     = rd_slot.qp;
							resp.found_tag    = rd_slot.tag;
						end else begin
							resp_status = STAT_MISS;
						end
					end
					default: begin
						resp_load = 1'b1;
					end
				endcase
			end
			S_SCAN: begin
				if (scan_rd) begin
					scan_addr_d = scan_addr_q + IDX_W'(1);
					scan_left_d = scan_left_q - CNT_W'(1);
				end
				// slot read last cycle is judged and written back now
				if (scan_hit) begin
					wr_en         = 1'b1;
					wr_addr       = scan_addr_s1;
					wr_slot       = rd_slot;
					wr_slot.valid = 1'b0;
					bytes_d       = bytes_q - {{(BYTES_W-LEN_W){1'b0}}, rd_slot.length};
					cnt_d         = cnt_q - CNT_W'(1);
				end
				if (scan_left_q == '0) begin
					ack_d     = req_q.psn;
					resp_load = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase

		if (cfg_first_wr) begin
			state_d   = S_CLEAR;
			clr_idx_d = '0;
			ack_d     = cfg_data - PSN_W'(1);
			low_d     = cfg_data;
			high_d    = cfg_data;
			cnt_d     = '0;
			bytes_d   = '0;
		end

		resp.held_count  = HELD_W'(cnt_d);
		resp.held_bytes  = bytes_d;
		resp.lowest_psn  = low_d;
		resp.highest_psn = high_d;
		resp.acked_psn   = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_psn_q   <= '0;
			byte_limit_q <= LIMIT_RESET;
			ack_q        <= '1;
			low_q        <= '0;
			high_q       <= '0;
			cnt_q        <= '0;
			bytes_q      <= '0;
			clr_idx_q    <= '0;
			scan_left_q  <= '0;
			scan_pend_s1 <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && (cfg_index == CFG_BASE_PSN)) begin
				base_psn_q <= cfg_data;
			end
			if (cfg_valid && (cfg_index == CFG_BYTE_LIMIT)) begin
				byte_limit_q <= cfg_data;
			end
			ack_q        <= ack_d;
			low_q        <= low_d;
			high_q       <= high_d;
			cnt_q        <= cnt_d;
			bytes_q      <= bytes_d;
			clr_idx_q    <= clr_idx_d;
			scan_left_q  <= scan_left_d;
			scan_pend_s1 <= scan_rd;
			if (resp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= cmd_t'(s_tuser);
			req_q <= req_in;
			idx_q <= in_idx;
		end
		scan_addr_q  <= scan_addr_d;
		scan_addr_s1 <= scan_addr_q;
		if (resp_load) begin
			m_tuser_q <= resp_status;
			m_tdata_q <= OUT_DATA_W'(resp);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: rtl/prrb_chk.sv
// Port-level checker for the retransmit buffer, bound to the top level.
// Depends on prrb_pkg and psn_ring_retransmit_buffer_top_macros.svh.
`include "psn_ring_retransmit_buffer_top_macros.svh"

module prrb_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [prrb_pkg::CMD_W-1:0]      s_tuser,
	input logic [prrb_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [prrb_pkg::STAT_W-1:0]     m_tuser,
	input logic [prrb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [prrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [prrb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prrb_pkg::*;

	`PRRB_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid,
		"result withdrawn while stalled")
	`PRRB_ASSERT_NEXT(a_out_data_holds, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`PRRB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"second request taken before the first finished")
	`PRRB_ASSERT_NEXT(a_out_empty_after_req, clk, arst_n, s_tvalid && s_tready, !m_tvalid,
		"request taken while an old result still waits")
	`PRRB_ASSERT_SAME(a_found_zero_unless_ok, clk, arst_n,
		m_tvalid && (m_tuser != STAT_OK), m_tdata[FOUND_W-1:0] == '0,
		"found fields nonzero on a failed request")

endmodule

bind psn_ring_retransmit_buffer_top prrb_chk u_prrb_chk (.*);

FILE: test/prrb_ring_monitor.sv
// Checker for the psn ring retransmit buffer: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on prrb_pkg.
module prrb_ring_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [prrb_pkg::CMD_W-1:0]      s_tuser,   // command
	input  logic [prrb_pkg::IN_DATA_W-1:0]  s_tdata,   // psn, length, queue_pair, buffer_tag
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [prrb_pkg::STAT_W-1:0]     m_tuser,   // status
	// found_length, found_qp, found_tag, held_count, held_bytes, lowest_psn,
	// highest_psn, acked_psn, zero pad
	input  logic [prrb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [prrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prrb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import prrb_pkg::*;

	typedef struct packed {
		status_t status;
		resp_t   fields;
	} outcome_t;

	outcome_t outcome_q[$];

	logic [PSN_W-1:0]   ring_base;
	logic [BYTES_W-1:0] byte_cap;
	logic               slot_live [RING_DEPTH];
	logic [PSN_W-1:0]   slot_psn  [RING_DEPTH];
	logic [LEN_W-1:0]   slot_len  [RING_DEPTH];
	logic [QP_W-1:0]    slot_qp   [RING_DEPTH];
	logic [TAG_W-1:0]   slot_tag  [RING_DEPTH];
	logic [PSN_W-1:0]   acked;
	logic [PSN_W-1:0]   low_seen;
	logic [PSN_W-1:0]   high_seen;
	logic [HELD_W-1:0]  live_count;
	logic [BYTES_W-1:0] live_bytes;

	task automatic clear_ring();
		for (int i = 0; i < RING_DEPTH; i++)
			slot_live[i] = 1'b0;
		acked      = ring_base - 32'd1;
		low_seen   = ring_base;
		high_seen  = ring_base;
		live_count = '0;
		live_bytes = '0;
	endtask

	task automatic free_slot(input int idx);
		if (slot_live[idx]) begin
			slot_live[idx] = 1'b0;
			live_bytes     = live_bytes - BYTES_W'(slot_len[idx]);
			live_count     = live_count - 1'b1;
		end
	endtask

	// releases every held packet with acked < psn <= upto
	task automatic release_thru(input logic [PSN_W-1:0] upto);
		if (upto <= acked)
			return;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (slot_live[i] && slot_psn[i] > acked && slot_psn[i] <= upto)
				free_slot(i);
		end
		acked = upto;
	endtask

	task automatic predict(input logic [CMD_W-1:0] cmd, input req_t req, output outcome_t res);
		logic [PSN_W-1:0] delta;
		int               idx;
		delta      = req.psn - ring_base;
		idx        = int'(delta[IDX_W-1:0]);
		res        = '0;
		res.status = STAT_OK;
		case (cmd)
			CMD_INSERT: begin
				if (req.length == '0) begin
					res.status = STAT_BAD_LEN;
				end else begin
					free_slot(idx);
					if ({1'b0, live_bytes} + {17'b0, req.length} > {1'b0, byte_cap}) begin
						res.status = STAT_OVER_LIM;
					end else begin
						slot_live[idx] = 1'b1;
						slot_psn[idx]  = req.psn;
						slot_len[idx]  = req.length;
						slot_qp[idx]   = req.queue_pair;
						slot_tag[idx]  = req.buffer_tag;
						live_bytes     = live_bytes + BYTES_W'(req.length);
						live_count     = live_count + 1'b1;
						if (req.psn < low_seen)
							low_seen = req.psn;
						if (req.psn > high_seen)
							high_seen = req.psn;
						// next expected psn acknowledges itself
						if (req.psn == acked + 32'd1)
							release_thru(req.psn);
					end
				end
			end
			CMD_ACK: begin
				release_thru(req.psn);
			end
			CMD_LOOKUP: begin
				if (slot_live[idx] && slot_psn[idx] == req.psn) begin
					res.fields.found_length = slot_len[idx];
					res.fields.found_qp     = slot_qp[idx];
					res.fields.found_tag    = slot_tag[idx];
				end else begin
					res.status = STAT_MISS;
				end
			end
			default: ;
		endcase
		res.fields.held_count  = live_count;
		res.fields.held_bytes  = live_bytes;
		res.fields.lowest_psn  = low_seen;
		res.fields.highest_psn = high_seen;
		res.fields.acked_psn   = acked;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (fail_count < 40)
			$display("mismatch %s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	task automatic compare_result(input logic [STAT_W-1:0] st, input resp_t got);
		outcome_t want;
		if (outcome_q.size() == 0) begin
			report("result with no request pending", 64'(st), 64'd0);
			return;
		end
		want = outcome_q.pop_front();
		if (st != want.status)
			report("status", 64'(st), 64'(want.status));
		if (got.found_length != want.fields.found_length)
			report("found_length", 64'(got.found_length), 64'(want.fields.found_length));
		if (got.found_qp != want.fields.found_qp)
			report("found_qp", 64'(got.found_qp), 64'(want.fields.found_qp));
		if (got.found_tag != want.fields.found_tag)
			report("found_tag", 64'(got.found_tag), 64'(want.fields.found_tag));
		if (got.held_count != want.fields.held_count)
			report("held_count", 64'(got.held_count), 64'(want.fields.held_count));
		if (got.held_bytes != want.fields.held_bytes)
			report("held_bytes", 64'(got.held_bytes), 64'(want.fields.held_bytes));
		if (got.lowest_psn != want.fields.lowest_psn)
			report("lowest_psn", 64'(got.lowest_psn), 64'(want.fields.lowest_psn));
		if (got.highest_psn != want.fields.highest_psn)
			report("highest_psn", 64'(got.highest_psn), 64'(want.fields.highest_psn));
		if (got.acked_psn != want.fields.acked_psn)
			report("acked_psn", 64'(got.acked_psn), 64'(want.fields.acked_psn));
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t res;
		if (!arst_n) begin
			fail_count = 0;
			outcome_q.delete();
			ring_base  = '0;
			byte_cap   = LIMIT_RESET;
			clear_ring();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BASE_PSN) begin
					ring_base = cfg_data;
					clear_ring();
				end else if (cfg_index == CFG_BYTE_LIMIT) begin
					byte_cap = cfg_data;
				end
			end
			if (m_tvalid && m_tready)
				compare_result(m_tuser, resp_t'(m_tdata[OUT_FIELDS_W-1:0]));
			if (s_tvalid && s_tready) begin
				predict(s_tuser, req_t'(s_tdata), res);
				outcome_q.push_back(res);
			end
		end
	end

endmodule

FILE: test/psn_ring_retransmit_buffer_top_tb.sv
// Testbench top for psn_ring_retransmit_buffer_top: directed and random
// request streams over several register settings and pacing modes.
// Depends on prrb_pkg, the block and prrb_ring_monitor.
module psn_ring_retransmit_buffer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prrb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
	localparam int               QUIET_LIMIT = 30000;
	localparam int               TAIL_CYCLES = 20;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [STAT_W-1:0]     m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int requests_sent  = 0;
	int results_seen   = 0;
	int quiet_cycles   = 0;

	// rough view of the sequence, used only to shape stimulus
	logic [PSN_W-1:0] next_psn;
	logic [PSN_W-1:0] ack_est;

	psn_ring_retransmit_buffer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	prrb_ring_monitor chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			results_seen <= results_seen + 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PSN_W-1:0] psn,
			input logic [LEN_W-1:0] len, input logic [QP_W-1:0] qp,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {tag, qp, len, psn};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	// stop sending and wait until every request has its result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_seen != requests_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count, input int pause_at);
		logic [CMD_W-1:0] cmd;
		logic [PSN_W-1:0] psn;
		logic [LEN_W-1:0] len;
		logic [QP_W-1:0]  qp;
		logic [TAG_W-1:0] tag;
		int               pick;
		for (int n = 0; n < count; n++) begin
			if (n == pause_at)
				settle();
			pick = $urandom_range(0, 99);
			if (pick < 5)
				len = '0;
			else if (pick < 40)
				len = 16'($urandom_range(1, 64));
			else
				len = 16'($urandom);
			qp   = 24'($urandom);
			tag  = $urandom;
			cmd  = CMD_INSERT;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// in-order insert, sometimes leaving a hole
				if ($urandom_range(0, 3) == 0)
					next_psn = next_psn + 32'($urandom_range(1, 4));
				psn      = next_psn;
				next_psn = next_psn + 32'd1;
			end else if (pick < 48) begin
				psn = ack_est + 32'd1;
			end else if (pick < 66) begin
				cmd = CMD_LOOKUP;
				psn = next_psn - 32'($urandom_range(1, 40));
			end else if (pick < 80) begin
				cmd = CMD_ACK;
				if ($urandom_range(0, 5) == 0) begin
					psn = ack_est - 32'($urandom_range(0, 8));
				end else begin
					psn = ack_est + 32'($urandom_range(1, 24));
					if (psn > ack_est)
						ack_est = psn;
				end
			end else if (pick < 84) begin
				cmd = CMD_SPARE;
				psn = $urandom;
			end else if (pick < 94) begin
				cmd = 2'($urandom_range(0, 3));
				if (cmd == CMD_ACK)
					cmd = CMD_LOOKUP;
				psn = $urandom;
			end else if (pick < 97) begin
				// acknowledge far ahead: long scan
				cmd = CMD_ACK;
				psn = $urandom;
				if (psn > ack_est) begin
					ack_est  = psn;
					next_psn = psn + 32'($urandom_range(1, 6));
				end
			end else begin
				// lands on a slot already used by a recent psn
				psn = next_psn - 32'd1 - 32'(RING_DEPTH * $urandom_range(1, 2));
			end
			send_item(cmd, psn, len, qp, tag);
		end
	endtask

	initial begin
		logic [PSN_W-1:0] base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: base of zero, nothing can be acknowledged
		send_item(CMD_ACK, 32'd5, 16'd0, 24'd0, 32'd0);
		send_item(CMD_INSERT, 32'd7, 16'd0, 24'h123456, 32'h1);
		send_item(CMD_INSERT, 32'd0, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_item(CMD_LOOKUP, 32'd0, 16'd0, 24'd0, 32'd0);
		send_item(CMD_LOOKUP, 32'(RING_DEPTH), 16'd0, 24'd0, 32'd0);
		send_item(CMD_INSERT, 32'(RING_DEPTH), 16'd1, 24'd0, 32'd0);
		send_item(CMD_LOOKUP, 32'd0, 16'd0, 24'd0, 32'd0);
		send_item(CMD_INSERT, 32'hFFFF_FFFF, 16'h8000, 24'h800000, 32'h8000_0000);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_item(CMD_SPARE, $urandom, 16'($urandom), 24'($urandom), $urandom);
		send_item(CMD_ACK, 32'hFFFF_FFFF, 16'd0, 24'd0, 32'd0);
		next_psn = 32'd1;
		ack_est  = 32'hFFFF_FFFF;
		run_random(60, -1);
		settle();

		write_reg(CFG_BASE_PSN, 32'd100);
		write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
		send_idle_pct = 78;
		send_item(CMD_INSERT, 32'd102, 16'd10, 24'd1, 32'hA);
		send_item(CMD_INSERT, 32'd101, 16'd20, 24'd2, 32'hB);
		send_item(CMD_INSERT, 32'd100, 16'd30, 24'd3, 32'hC);
		send_item(CMD_LOOKUP, 32'd101, 16'd0, 24'd0, 32'd0);
		send_item(CMD_ACK, 32'd102, 16'd0, 24'd0, 32'd0);
		send_item(CMD_INSERT, 32'd5, 16'd40, 24'd4, 32'hD);
		send_item(CMD_LOOKUP, 32'd5, 16'd0, 24'd0, 32'd0);
		send_item(CMD_LOOKUP, 32'd5 + 32'(RING_DEPTH), 16'd0, 24'd0, 32'd0);
		next_psn = 32'd103;
		ack_est  = 32'd102;
		run_random(90, -1);
		settle();

		// zero limit refuses every insert
		write_reg(CFG_BYTE_LIMIT, 32'd0);
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		run_random(40, -1);
		send_item(CMD_ACK, 32'hFFFF_FFFF, 16'd0, 24'd0, 32'd0);
		settle();

		write_reg(CFG_BASE_PSN, 32'hFFFF_FFF0);
		write_reg(CFG_BYTE_LIMIT, 32'd150000);
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		next_psn = 32'hFFFF_FFF0;
		ack_est  = 32'hFFFF_FFEF;
		run_random(110, 55);
		settle();

		write_reg(CFG_BASE_PSN, 32'hFFFF_FFFF);
		write_reg(CFG_BYTE_LIMIT, LIMIT_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		next_psn = 32'hFFFF_FFFF;
		ack_est  = 32'hFFFF_FFFE;
		run_random(90, -1);
		settle();

		write_reg(CFG_BASE_PSN, 32'd0);
		write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
		send_idle_pct = 78;
		next_psn = 32'd0;
		ack_est  = 32'hFFFF_FFFF;
		run_random(70, -1);
		settle();

		base = $urandom;
		write_reg(CFG_BASE_PSN, base);
		write_reg(CFG_BYTE_LIMIT, 32'($urandom_range(100000, 2000000)));
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		next_psn = base;
		ack_est  = base - 32'd1;
		run_random(100, -1);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/prrb_pkg.sv
rtl/prrb_ram.sv
rtl/psn_ring_retransmit_buffer_top.sv
rtl/prrb_chk.sv
test/prrb_ring_monitor.sv
test/psn_ring_retransmit_buffer_top_tb.sv
